@@ hdl/rdcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdcc_pkg
// shared types, constants and helpers of the run-length decimal count codec
// ----------------------------------------------------------------------------
package rdcc_pkg;

	localparam int          BCD_W     = 20;
	localparam logic [7:0]  CHAR_ZERO = 8'h30;
	localparam logic [7:0]  CHAR_NINE = 8'h39;
	localparam logic [19:0] BCD_ONE   = 20'h00001;
	localparam logic [2:0]  TOP_DIGIT = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIGIT,
		S_CHAR,
		S_TAIL,
		S_DEC
	} state_t;

	typedef enum logic [1:0] {
		SRC_DIGIT,
		SRC_CHAR,
		SRC_TAIL,
		SRC_DEC
	} src_t;

	typedef struct packed {
		logic accept;
		logic emit;
		src_t sel;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic acc_emit;
		logic acc_dec;
		logic acc_lit;
		logic fl_two;
		logic dig_zero;
		logic tail;
	} sts_t;

	// five-digit bcd increment, wraps at 99999
	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		logic             c;
		logic [4:0]       d;
		r = '0;
		c = 1'b1;
		for (int k = 0; k < 5; k++) begin
			d = {1'b0, v[4*k +: 4]} + {4'b0, c};
			if (d > 5'd9) begin
				r[4*k +: 4] = 4'd0;
				c = 1'b1;
			end else begin
				r[4*k +: 4] = d[3:0];
				c = 1'b0;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rdcc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdcc_ctrl
// sequencer: accepts items and steps through the results of each one
// ----------------------------------------------------------------------------
module rdcc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire rdcc_pkg::sts_t sts,
	output rdcc_pkg::cmd_t     cmd
);

	rdcc_pkg::state_t state_q;
	rdcc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdcc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdcc_pkg::S_IDLE: begin
				if (cmd.accept && sts.acc_emit) begin
					if (sts.acc_dec)
						state_d = rdcc_pkg::S_DEC;
					else if (sts.acc_lit)
						state_d = rdcc_pkg::S_CHAR;
					else
						state_d = rdcc_pkg::S_DIGIT;
				end
			end
			rdcc_pkg::S_DIGIT: begin
				if (cmd.emit && sts.dig_zero)
					state_d = rdcc_pkg::S_CHAR;
			end
			rdcc_pkg::S_CHAR: begin
				// a literal pair stays here for its second copy
				if (cmd.emit && !sts.fl_two)
					state_d = sts.tail ? rdcc_pkg::S_TAIL : rdcc_pkg::S_IDLE;
			end
			rdcc_pkg::S_TAIL: begin
				if (cmd.emit)
					state_d = rdcc_pkg::S_IDLE;
			end
			rdcc_pkg::S_DEC: begin
				if (cmd.emit)
					state_d = rdcc_pkg::S_IDLE;
			end
			default: state_d = rdcc_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = (state_q == rdcc_pkg::S_IDLE);
		cmd.accept = s_tvalid && s_tready;
		cmd.emit   = (state_q != rdcc_pkg::S_IDLE) && sts.slot_free;
		case (state_q)
			rdcc_pkg::S_DIGIT: cmd.sel = rdcc_pkg::SRC_DIGIT;
			rdcc_pkg::S_CHAR:  cmd.sel = rdcc_pkg::SRC_CHAR;
			rdcc_pkg::S_TAIL:  cmd.sel = rdcc_pkg::SRC_TAIL;
			default:           cmd.sel = rdcc_pkg::SRC_DEC;
		endcase
	end

	a_emit_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.acc_emit |=> state_q != rdcc_pkg::S_IDLE)
		else $error("item with results did not start the sequence");

	a_quiet_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rdcc_pkg::S_IDLE && !(cmd.accept && sts.acc_emit)
		|=> state_q == rdcc_pkg::S_IDLE)
		else $error("sequencer left idle without a result to send");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free && !s_tready)
		else $error("result written while output slot busy or while accepting");

endmodule
`default_nettype wire

@@ hdl/rdcc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdcc_dp
// datapath: run and digit state, flush snapshot and the output register
// ----------------------------------------------------------------------------
module rdcc_dp #(
	parameter int MAX_RUN = 65535
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     s_tdata,   // [7:0] in_byte
	input  wire logic           s_tlast,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [23:0]         m_tdata,   // [7:0] out_byte, [23:8] out_repeat
	output logic                m_tuser,   // [0] out_item_end
	output logic                m_tlast,
	input  wire logic           cfg_valid,
	input  wire logic           cfg_data,
	input  wire rdcc_pkg::cmd_t cmd,
	output rdcc_pkg::sts_t      sts
);

	localparam int              CW    = $clog2(MAX_RUN + 1);
	localparam int              CAP   = (MAX_RUN < 65535) ? MAX_RUN : 65535;
	localparam logic [CW-1:0]   MAX_C = CW'(MAX_RUN);
	localparam logic [15:0]     CAP_V = 16'(CAP);

	// stream state
	logic                         mode_q;
	logic [7:0]                   run_char_q;
	logic [rdcc_pkg::BCD_W-1:0]   run_bcd_q;
	logic [CW-1:0]                run_cnt_q;
	logic                         run_active_q;
	logic [15:0]                  dig_cnt_q;
	logic                         dig_pend_q;

	// snapshot of the item being sent out
	logic [7:0]                   fl_char_q;
	logic [rdcc_pkg::BCD_W-1:0]   fl_bcd_q;
	logic                         fl_two_q;
	logic [2:0]                   dig_idx_q;
	logic [7:0]                   tail_char_q;
	logic                         tail_q;
	logic                         last_q;
	logic [7:0]                   dec_byte_q;
	logic [15:0]                  dec_rep_q;

	// output register
	logic                         m_tvalid_q;
	logic [7:0]                   out_byte_q;
	logic [15:0]                  out_rep_q;
	logic                         out_iend_q;
	logic                         out_send_q;

	logic                         join_run;
	logic [rdcc_pkg::BCD_W-1:0]   bcd_next;
	logic                         enc_flush;
	logic [7:0]                   snap_char;
	logic [rdcc_pkg::BCD_W-1:0]   snap_bcd;
	logic                         snap_tail;
	logic                         snap_lit;
	logic                         snap_two;
	logic [2:0]                   snap_top;
	logic                         is_dig;
	logic [19:0]                  dig_val;
	logic [15:0]                  dig_sat;
	logic                         dec_emit;
	logic                         cfg_wr;
	logic [3:0]                   cur_digit;
	logic [7:0]                   emit_byte;
	logic [15:0]                  emit_rep;
	logic                         emit_iend;

	assign cfg_wr = cfg_valid;

	// encode side of the accept decision
	always_comb begin
		bcd_next  = rdcc_pkg::bcd_inc(run_bcd_q);
		join_run  = run_active_q && (s_tdata == run_char_q) && (run_cnt_q < MAX_C);
		enc_flush = s_tlast || (!join_run && run_active_q);
		snap_char = run_active_q ? run_char_q : s_tdata;
		if (join_run)
			snap_bcd = bcd_next;
		else if (run_active_q)
			snap_bcd = run_bcd_q;
		else
			snap_bcd = rdcc_pkg::BCD_ONE;
		snap_tail = !join_run && run_active_q && s_tlast;
		snap_lit  = (snap_bcd[19:4] == '0) && (snap_bcd[3:0] <= 4'd2);
		snap_two  = (snap_bcd[19:4] == '0) && (snap_bcd[3:0] == 4'd2);
		if (snap_bcd[19:16] != 4'd0)
			snap_top = 3'd4;
		else if (snap_bcd[15:12] != 4'd0)
			snap_top = 3'd3;
		else if (snap_bcd[11:8] != 4'd0)
			snap_top = 3'd2;
		else if (snap_bcd[7:4] != 4'd0)
			snap_top = 3'd1;
		else
			snap_top = 3'd0;
	end

	// decode side: count * 10 as two shifts
	always_comb begin
		is_dig   = (s_tdata >= rdcc_pkg::CHAR_ZERO) && (s_tdata <= rdcc_pkg::CHAR_NINE);
		dig_val  = ({4'b0, dig_cnt_q} << 3) + ({4'b0, dig_cnt_q} << 1)
		           + {16'b0, s_tdata[3:0]};
		dig_sat  = (dig_val > {4'b0, CAP_V}) ? CAP_V : dig_val[15:0];
		dec_emit = !is_dig || s_tlast;
	end

	always_comb begin
		sts.slot_free = !m_tvalid_q || m_tready;
		sts.acc_emit  = mode_q ? dec_emit : enc_flush;
		sts.acc_dec   = mode_q;
		sts.acc_lit   = snap_lit;
		sts.fl_two    = fl_two_q;
		sts.dig_zero  = (dig_idx_q == 3'd0);
		sts.tail      = tail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			run_char_q   <= '0;
			run_bcd_q    <= '0;
			run_cnt_q    <= '0;
			run_active_q <= 1'b0;
			dig_cnt_q    <= '0;
			dig_pend_q   <= 1'b0;
		end else if (cfg_wr) begin
			mode_q       <= cfg_data;
			run_char_q   <= '0;
			run_bcd_q    <= '0;
			run_cnt_q    <= '0;
			run_active_q <= 1'b0;
			dig_cnt_q    <= '0;
			dig_pend_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (!mode_q) begin
				if (s_tlast) begin
					run_char_q   <= '0;
					run_bcd_q    <= '0;
					run_cnt_q    <= '0;
					run_active_q <= 1'b0;
				end else if (join_run) begin
					run_bcd_q <= bcd_next;
					run_cnt_q <= run_cnt_q + CW'(1);
				end else begin
					run_char_q   <= s_tdata;
					run_bcd_q    <= rdcc_pkg::BCD_ONE;
					run_cnt_q    <= CW'(1);
					run_active_q <= 1'b1;
				end
			end else begin
				if (is_dig && !s_tlast) begin
					dig_cnt_q  <= dig_sat;
					dig_pend_q <= 1'b1;
				end else begin
					dig_cnt_q  <= '0;
					dig_pend_q <= 1'b0;
				end
			end
		end
	end

	// sequencing bits of the snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_two_q  <= 1'b0;
			dig_idx_q <= '0;
			tail_q    <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.accept) begin
			fl_two_q  <= snap_two;
			dig_idx_q <= snap_top;
			tail_q    <= snap_tail;
			last_q    <= s_tlast;
		end else if (cmd.emit) begin
			if (cmd.sel == rdcc_pkg::SRC_DIGIT)
				dig_idx_q <= dig_idx_q - 3'd1;
			if (cmd.sel == rdcc_pkg::SRC_CHAR)
				fl_two_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fl_char_q   <= snap_char;
			fl_bcd_q    <= snap_bcd;
			tail_char_q <= s_tdata;
			// a digit here can only be a trailing one: empty end marker
			dec_byte_q  <= is_dig ? 8'd0 : s_tdata;
			dec_rep_q   <= is_dig ? 16'd0 : (dig_pend_q ? dig_cnt_q : 16'd1);
		end
	end

	always_comb begin
		case (dig_idx_q)
			3'd0:    cur_digit = fl_bcd_q[3:0];
			3'd1:    cur_digit = fl_bcd_q[7:4];
			3'd2:    cur_digit = fl_bcd_q[11:8];
			3'd3:    cur_digit = fl_bcd_q[15:12];
			default: cur_digit = fl_bcd_q[19:16];
		endcase
		case (cmd.sel)
			rdcc_pkg::SRC_DIGIT: begin
				emit_byte = rdcc_pkg::CHAR_ZERO + {4'b0, cur_digit};
				emit_rep  = 16'd1;
				emit_iend = 1'b0;
			end
			rdcc_pkg::SRC_CHAR: begin
				emit_byte = fl_char_q;
				emit_rep  = 16'd1;
				emit_iend = !fl_two_q && !tail_q;
			end
			rdcc_pkg::SRC_TAIL: begin
				emit_byte = tail_char_q;
				emit_rep  = 16'd1;
				emit_iend = 1'b1;
			end
			default: begin
				emit_byte = dec_byte_q;
				emit_rep  = dec_rep_q;
				emit_iend = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_rep_q  <= emit_rep;
			out_iend_q <= emit_iend;
			out_send_q <= emit_iend && last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_rep_q, out_byte_q};
	assign m_tuser  = out_iend_q;
	assign m_tlast  = out_send_q;

	a_run_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> run_cnt_q != '0 && run_bcd_q != '0)
		else $error("open run with zero length");

	a_count_needs_digits: assert property (@(posedge clk) disable iff (!arst_n)
		!dig_pend_q |-> dig_cnt_q == '0)
		else $error("decode count held without pending digits");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		dig_cnt_q <= CAP_V)
		else $error("decode count above its limit");

	a_digit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.sel == rdcc_pkg::SRC_DIGIT |-> dig_idx_q <= rdcc_pkg::TOP_DIGIT)
		else $error("digit index beyond the count");

endmodule
`default_nettype wire

@@ hdl/rle_decimal_count_codec_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rle_decimal_count_codec_top
// byte-stream run-length codec with decimal counts, encode or decode by mode
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one byte per transaction, s_tlast on the final byte of a
//   string. m_* carries one result per transaction: byte and repeat count in
//   m_tdata, m_tuser marks the last result of an input byte, m_tlast the
//   last result of the string. cfg_* writes the mode bit (0 encode, 1
//   decode) and clears all run and digit state; write it only while idle.
// timing:
//   a byte that produces no result (a byte that extends a run, a decode
//   digit) leaves the sequencer idle, so such bytes stream at one per cycle.
//   a byte with results is accepted first; then the sequencer writes its
//   1 to 7 results one at a time into the single output register it fills,
//   each once that register is free, and m_tvalid rises with the first.
// reset: mode is encode and no run or digit count is open.
// stall: while the output register is full and m_tready is low the sequencer
//   holds its place and s_tready stays low until every result of the current
//   byte has been written into the output register; nothing is dropped.
// ----------------------------------------------------------------------------
module rle_decimal_count_codec_top #(
	parameter int MAX_RUN = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_repeat
	output logic             m_tuser,   // [0] out_item_end
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	rdcc_pkg::cmd_t cmd;
	rdcc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rdcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rdcc_dp #(
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire
